@@ src/bbcd_pkg.sv @@
package bbcd_pkg;

  localparam int ENTRIES = 64;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);

  localparam logic [15:0] REFS_MAX = 16'hFFFF;

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_GET     = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_DIRTY   = 3'd3;
  localparam logic [2:0] OP_WDONE   = 3'd4;
  localparam logic [2:0] OP_FFAIL   = 3'd5;
  localparam logic [2:0] OP_INVAL   = 3'd6;

  localparam logic [2:0] ST_HIT     = 3'd0;
  localparam logic [2:0] ST_MISS    = 3'd1;
  localparam logic [2:0] ST_ALLOC   = 3'd2;
  localparam logic [2:0] ST_DONE    = 3'd3;
  localparam logic [2:0] ST_NOSPACE = 3'd4;
  localparam logic [2:0] ST_BADSLOT = 3'd5;

  typedef struct packed {
    logic [7:0]       dev;
    logic [47:0]      blk;
    logic [15:0]      refs;
    logic [IDX_W-1:0] rec;
  } entry_t;

endpackage

@@ src/bbcd_in_if.sv @@
interface bbcd_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [7:0]  device_id;
  logic [47:0] block_number;
  logic [5:0]  slot;

  modport source (output valid, opcode, device_id, block_number, slot, input ready);
  modport sink (input valid, opcode, device_id, block_number, slot, output ready);
endinterface

@@ src/bbcd_out_if.sv @@
interface bbcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [5:0]  slot_res;
  logic [63:0] hit_count;
  logic [63:0] miss_count;
  logic [6:0]  dirty_count;
  logic [6:0]  occupied_count;

  modport source (output valid, status, slot_res, hit_count, miss_count, dirty_count,
                  occupied_count, input ready);
  modport sink (input valid, status, slot_res, hit_count, miss_count, dirty_count,
                occupied_count, output ready);
endinterface

@@ src/block_buffer_cache_directory_top.sv @@
// Block buffer cache directory.
// in_ch carries one request item (opcode, device_id, block_number, slot) under
// valid/ready; out_ch returns exactly one result item per request, held in an
// output register until taken. cfg_we/cfg_wdata write max_entries (reset 64);
// the user must write it only while the block is idle, which is not enforced.
// Entry tags, refcounts and LRU ranks sit in one synchronous memory; valid and
// dirty marks are flip-flops. Every pass streams entries in order through the
// memory read port, one per cycle, with write-back behind it; a lookup pass
// stops at its hit. A miss runs a victim and a drop pass per eviction, then an
// allocation pass; invalidate_device runs a drop pass per dropped entry.
// One item is worked on at a time; in_ch.ready is high only when idle.
// Reset (synchronous, rst_n low) clears valid/dirty marks, the counters and
// the output register; no clearing pass is needed.
// When out_ch stalls, a finished result waits in its state until the output
// register is free, and no new item is taken meanwhile.
module block_buffer_cache_directory_top import bbcd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_we,
  input  logic [6:0]    cfg_wdata,
  bbcd_in_if.sink       in_ch,
  bbcd_out_if.source    out_ch
);

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_LOOKUP, S_RECENT, S_EVCHK, S_VICTIM,
    S_DROP, S_INVAL, S_ALLOC, S_ALLOC_WR, S_RESP
  } state_t;

  typedef enum logic [1:0] {RET_EVICT, RET_INVAL, RET_RESP} ret_t;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;
  logic             rd_en, we;
  logic [IDX_W-1:0] rd_addr, wa;
  entry_t           wd;

  state_t state_r, state_nxt;
  ret_t   ret_r, ret_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pi_r, pi_nxt;
  logic [2:0]       op_r, op_nxt;
  logic [7:0]       dev_r, dev_nxt;
  logic [47:0]      blk_r, blk_nxt;
  logic [IDX_W-1:0] slot_r, slot_nxt;
  logic [IDX_W-1:0] tgt_r, tgt_nxt, rank_r, rank_nxt, free_r, free_nxt;
  logic             vfound_r, vfound_nxt, stop_r, stop_nxt, ffound_r, ffound_nxt;
  logic [2:0]       res_st_r, res_st_nxt;
  logic [IDX_W-1:0] res_slot_r, res_slot_nxt;
  logic [63:0]      hits_r, hits_nxt, misses_r, misses_nxt;
  logic [CNT_W-1:0] dcnt_r, dcnt_nxt, occ_r, occ_nxt;
  logic [6:0]       max_r;
  logic [ENTRIES-1:0] valid_r, valid_nxt, dirty_r, dirty_nxt;

  logic        ov_r, ov_nxt;
  logic [2:0]  o_st_r, o_st_nxt;
  logic [5:0]  o_slot_r, o_slot_nxt;
  logic [63:0] o_hits_r, o_hits_nxt, o_miss_r, o_miss_nxt;
  logic [6:0]  o_dcnt_r, o_dcnt_nxt, o_occ_r, o_occ_nxt;

  logic             acc, issue, last, pv_ent, slot_ok, cand;
  logic [IDX_W-1:0] sidx;
  entry_t           d;

  assign in_ch.ready         = (state_r == S_IDLE);
  assign acc                 = in_ch.valid && in_ch.ready;
  assign out_ch.valid        = ov_r;
  assign out_ch.status       = o_st_r;
  assign out_ch.slot_res     = o_slot_r;
  assign out_ch.hit_count    = o_hits_r;
  assign out_ch.miss_count   = o_miss_r;
  assign out_ch.dirty_count  = o_dcnt_r;
  assign out_ch.occupied_count = o_occ_r;

  assign d       = rd_data_r;
  assign issue   = (cnt_r < CNT_W'(ENTRIES));
  assign last    = !issue;
  assign pv_ent  = pv_r && valid_r[pi_r];
  assign slot_ok = int'(in_ch.slot) < ENTRIES;
  assign sidx    = IDX_W'(in_ch.slot);
  assign cand    = pv_ent && (d.refs == 16'd0) && !dirty_r[pi_r] &&
                   (!vfound_r || (d.rec > rank_r));

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[rd_addr];
    if (we) mem[wa] <= wd;
  end

  always_comb begin
    state_nxt = state_r;  ret_nxt = ret_r;
    cnt_nxt = cnt_r;      pv_nxt = 1'b0;      pi_nxt = pi_r;
    op_nxt = op_r;        dev_nxt = dev_r;    blk_nxt = blk_r;  slot_nxt = slot_r;
    tgt_nxt = tgt_r;      rank_nxt = rank_r;  free_nxt = free_r;
    vfound_nxt = vfound_r; stop_nxt = stop_r; ffound_nxt = ffound_r;
    res_st_nxt = res_st_r; res_slot_nxt = res_slot_r;
    hits_nxt = hits_r;    misses_nxt = misses_r;
    dcnt_nxt = dcnt_r;    occ_nxt = occ_r;
    valid_nxt = valid_r;  dirty_nxt = dirty_r;
    ov_nxt = ov_r && !out_ch.ready;
    o_st_nxt = o_st_r;    o_slot_nxt = o_slot_r;
    o_hits_nxt = o_hits_r; o_miss_nxt = o_miss_r;
    o_dcnt_nxt = o_dcnt_r; o_occ_nxt = o_occ_r;
    rd_en = 1'b0;  rd_addr = cnt_r[IDX_W-1:0];
    we = 1'b0;     wa = pi_r;  wd = d;

    // streaming pass: one read issued per cycle, its data handled next cycle
    if (state_r == S_LOOKUP || state_r == S_RECENT || state_r == S_VICTIM ||
        state_r == S_DROP || state_r == S_INVAL || state_r == S_ALLOC) begin
      rd_en = issue;
      pv_nxt = issue;
      pi_nxt = cnt_r[IDX_W-1:0];
      if (issue) cnt_nxt = cnt_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          op_nxt = in_ch.opcode;
          dev_nxt = in_ch.device_id;
          blk_nxt = in_ch.block_number;
          slot_nxt = sidx;
          stop_nxt = 1'b0;
          res_slot_nxt = '0;
          res_st_nxt = ST_DONE;
          cnt_nxt = '0;
          case (in_ch.opcode) inside
            OP_READ, OP_GET: state_nxt = S_LOOKUP;
            OP_INVAL: state_nxt = S_INVAL;
            OP_RELEASE, OP_DIRTY, OP_WDONE, OP_FFAIL: begin
              if (!slot_ok || !valid_r[sidx]) begin
                res_st_nxt = ST_BADSLOT;
                state_nxt = S_RESP;
              end else if (in_ch.opcode == OP_DIRTY) begin
                if (!dirty_r[sidx]) begin
                  dirty_nxt[sidx] = 1'b1;
                  dcnt_nxt = dcnt_r + 1'b1;
                end
                state_nxt = S_RESP;
              end else if (in_ch.opcode == OP_WDONE) begin
                if (dirty_r[sidx]) begin
                  dirty_nxt[sidx] = 1'b0;
                  if (dcnt_r != '0) dcnt_nxt = dcnt_r - 1'b1;
                end
                state_nxt = S_RESP;
              end else begin
                rd_en = 1'b1;
                rd_addr = sidx;
                state_nxt = S_SLOT;
              end
            end
            default: begin
              res_st_nxt = ST_BADSLOT;
              state_nxt = S_RESP;
            end
          endcase
        end
      end
      S_SLOT: begin
        if (op_r == OP_RELEASE) begin
          if (d.refs != 16'd0) begin
            we = 1'b1;
            wa = slot_r;
            wd.refs = d.refs - 16'd1;
          end
          state_nxt = S_RESP;
        end else begin
          tgt_nxt = slot_r;
          rank_nxt = d.rec;
          ret_nxt = RET_RESP;
          cnt_nxt = '0;
          state_nxt = S_DROP;
        end
      end
      S_LOOKUP: begin
        if (pv_ent && d.dev == dev_r && d.blk == blk_r) begin
          tgt_nxt = pi_r;
          rank_nxt = d.rec;
          cnt_nxt = '0;
          pv_nxt = 1'b0;
          state_nxt = S_RECENT;
        end else if (last) begin
          if (op_r == OP_READ) misses_nxt = misses_r + 64'd1;
          state_nxt = S_EVCHK;
        end
      end
      S_RECENT: begin
        if (pv_ent) begin
          if (pi_r == tgt_r) begin
            we = 1'b1;
            if (d.refs != REFS_MAX) wd.refs = d.refs + 16'd1;
            wd.rec = '0;
          end else if (d.rec < rank_r) begin
            we = 1'b1;
            wd.rec = d.rec + 1'b1;
          end
        end
        if (last) begin
          if (op_r == OP_READ) hits_nxt = hits_r + 64'd1;
          res_st_nxt = ST_HIT;
          res_slot_nxt = tgt_r;
          state_nxt = S_RESP;
        end
      end
      S_EVCHK: begin
        cnt_nxt = '0;
        if ((32'(occ_r) > 32'(max_r)) && !stop_r) begin
          vfound_nxt = 1'b0;
          state_nxt = S_VICTIM;
        end else if (occ_r < CNT_W'(ENTRIES)) begin
          ffound_nxt = 1'b0;
          state_nxt = S_ALLOC;
        end else begin
          res_st_nxt = ST_NOSPACE;
          res_slot_nxt = '0;
          state_nxt = S_RESP;
        end
      end
      S_VICTIM: begin
        if (cand) begin
          vfound_nxt = 1'b1;
          tgt_nxt = pi_r;
          rank_nxt = d.rec;
        end
        if (last) begin
          cnt_nxt = '0;
          if (vfound_r || cand) begin
            ret_nxt = RET_EVICT;
            state_nxt = S_DROP;
          end else begin
            stop_nxt = 1'b1;
            state_nxt = S_EVCHK;
          end
        end
      end
      S_DROP: begin
        if (pv_ent && pi_r != tgt_r && d.rec > rank_r) begin
          we = 1'b1;
          wd.rec = d.rec - 1'b1;
        end
        if (last) begin
          valid_nxt[tgt_r] = 1'b0;
          dirty_nxt[tgt_r] = 1'b0;
          if (dirty_r[tgt_r] && dcnt_r != '0) dcnt_nxt = dcnt_r - 1'b1;
          if (occ_r != '0) occ_nxt = occ_r - 1'b1;
          unique case (ret_r)
            RET_EVICT: state_nxt = S_EVCHK;
            RET_INVAL: begin
              cnt_nxt = CNT_W'(tgt_r) + CNT_W'(1);
              state_nxt = S_INVAL;
            end
            default: state_nxt = S_RESP;
          endcase
        end
      end
      S_INVAL: begin
        if (pv_ent && d.dev == dev_r) begin
          tgt_nxt = pi_r;
          rank_nxt = d.rec;
          ret_nxt = RET_INVAL;
          cnt_nxt = '0;
          pv_nxt = 1'b0;
          state_nxt = S_DROP;
        end else if (last) begin
          state_nxt = S_RESP;
        end
      end
      S_ALLOC: begin
        if (pv_r) begin
          if (valid_r[pi_r]) begin
            we = 1'b1;
            wd.rec = d.rec + 1'b1;
          end else if (!ffound_r) begin
            ffound_nxt = 1'b1;
            free_nxt = pi_r;
          end
        end
        if (last) state_nxt = S_ALLOC_WR;
      end
      S_ALLOC_WR: begin
        we = 1'b1;
        wa = free_r;
        wd.dev = dev_r;
        wd.blk = blk_r;
        wd.refs = 16'd1;
        wd.rec = '0;
        valid_nxt[free_r] = 1'b1;
        dirty_nxt[free_r] = 1'b0;
        occ_nxt = occ_r + 1'b1;
        res_st_nxt = (op_r == OP_READ) ? ST_MISS : ST_ALLOC;
        res_slot_nxt = free_r;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_ch.ready) begin
          ov_nxt = 1'b1;
          o_st_nxt = res_st_r;
          o_slot_nxt = 6'(res_slot_r);
          o_hits_nxt = hits_r;
          o_miss_nxt = misses_r;
          o_dcnt_nxt = 7'(dcnt_r);
          o_occ_nxt = 7'(occ_r);
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pv_r <= 1'b0;
      hits_r <= '0;
      misses_r <= '0;
      dcnt_r <= '0;
      occ_r <= '0;
      valid_r <= '0;
      dirty_r <= '0;
      ov_r <= 1'b0;
      max_r <= 7'd64;
    end else begin
      state_r <= state_nxt;
      pv_r <= pv_nxt;
      hits_r <= hits_nxt;
      misses_r <= misses_nxt;
      dcnt_r <= dcnt_nxt;
      occ_r <= occ_nxt;
      valid_r <= valid_nxt;
      dirty_r <= dirty_nxt;
      ov_r <= ov_nxt;
      if (cfg_we) max_r <= cfg_wdata;
    end
    ret_r <= ret_nxt;
    cnt_r <= cnt_nxt;
    pi_r <= pi_nxt;
    op_r <= op_nxt;
    dev_r <= dev_nxt;
    blk_r <= blk_nxt;
    slot_r <= slot_nxt;
    tgt_r <= tgt_nxt;
    rank_r <= rank_nxt;
    free_r <= free_nxt;
    vfound_r <= vfound_nxt;
    stop_r <= stop_nxt;
    ffound_r <= ffound_nxt;
    res_st_r <= res_st_nxt;
    res_slot_r <= res_slot_nxt;
    o_st_r <= o_st_nxt;
    o_slot_r <= o_slot_nxt;
    o_hits_r <= o_hits_nxt;
    o_miss_r <= o_miss_nxt;
    o_dcnt_r <= o_dcnt_nxt;
    o_occ_r <= o_occ_nxt;
  end

endmodule

@@ tb/sv/bbcd_dir_checker.sv @@
module bbcd_dir_checker import bbcd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [6:0] cfg_wdata,
  bbcd_in_if         in_ch,
  bbcd_out_if        out_ch,
  output int         errors,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [2:0]  status;
    logic [5:0]  slot_res;
    logic [63:0] hits;
    logic [63:0] misses;
    logic [6:0]  dirty;
    logic [6:0]  occupied;
  } dir_result_t;

  dir_result_t result_q[$];

  bit          m_valid[ENTRIES];
  logic [7:0]  m_dev[ENTRIES];
  logic [47:0] m_blk[ENTRIES];
  logic [15:0] m_refs[ENTRIES];
  bit          m_dirty[ENTRIES];
  int          m_rank[ENTRIES];
  logic [63:0] m_hits, m_misses;
  int          m_dirty_n, m_occ_n;
  int          m_limit;

  initial errors = 0;
  assign pending = result_q.size();

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic void promote(int e);
    int r;
    r = m_rank[e];
    for (int i = 0; i < ENTRIES; i++)
      if (m_valid[i] && i != e && m_rank[i] < r) m_rank[i]++;
    m_rank[e] = 0;
  endfunction

  function automatic void drop(int e);
    int r;
    r = m_rank[e];
    for (int i = 0; i < ENTRIES; i++)
      if (m_valid[i] && i != e && m_rank[i] > r) m_rank[i]--;
    if (m_dirty[e] && m_dirty_n > 0) m_dirty_n--;
    m_dirty[e] = 0;
    m_valid[e] = 0;
    if (m_occ_n > 0) m_occ_n--;
  endfunction

  function automatic void evict_to_limit();
    int victim;
    while (m_occ_n > m_limit) begin
      victim = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (m_valid[i] && m_refs[i] == 0 && !m_dirty[i] &&
            (victim < 0 || m_rank[i] > m_rank[victim])) victim = i;
      if (victim < 0) break;
      drop(victim);
    end
  endfunction

  function automatic dir_result_t predict_item(logic [2:0] op, logic [7:0] dev,
                                               logic [47:0] blk, logic [5:0] s);
    dir_result_t r;
    int e;
    int f;
    r.status = ST_DONE;
    r.slot_res = '0;
    if (op == OP_READ || op == OP_GET) begin
      e = -1;
      for (int i = 0; i < ENTRIES; i++)
        if (e < 0 && m_valid[i] && m_dev[i] == dev && m_blk[i] == blk) e = i;
      if (e >= 0) begin
        if (m_refs[e] != REFS_MAX) m_refs[e]++;
        promote(e);
        if (op == OP_READ) m_hits++;
        r.status = ST_HIT;
        r.slot_res = e[5:0];
      end else begin
        if (op == OP_READ) m_misses++;
        evict_to_limit();
        f = -1;
        for (int i = 0; i < ENTRIES; i++)
          if (f < 0 && !m_valid[i]) f = i;
        if (f < 0) begin
          r.status = ST_NOSPACE;
        end else begin
          m_valid[f] = 1;
          m_dev[f] = dev;
          m_blk[f] = blk;
          m_refs[f] = 16'd1;
          m_dirty[f] = 0;
          m_rank[f] = m_occ_n;
          m_occ_n++;
          promote(f);
          r.slot_res = f[5:0];
          r.status = (op == OP_READ) ? ST_MISS : ST_ALLOC;
        end
      end
    end else if (op == OP_INVAL) begin
      for (int i = 0; i < ENTRIES; i++)
        if (m_valid[i] && m_dev[i] == dev) drop(i);
    end else if (op <= OP_FFAIL) begin
      if (int'(s) >= ENTRIES || !m_valid[s]) begin
        r.status = ST_BADSLOT;
      end else if (op == OP_RELEASE) begin
        if (m_refs[s] != 0) m_refs[s]--;
      end else if (op == OP_DIRTY) begin
        if (!m_dirty[s]) begin
          m_dirty[s] = 1;
          m_dirty_n++;
        end
      end else if (op == OP_WDONE) begin
        if (m_dirty[s]) begin
          m_dirty[s] = 0;
          if (m_dirty_n > 0) m_dirty_n--;
        end
      end else begin
        drop(int'(s));
      end
    end else begin
      r.status = ST_BADSLOT;
    end
    r.hits = m_hits;
    r.misses = m_misses;
    r.dirty = m_dirty_n[6:0];
    r.occupied = m_occ_n[6:0];
    return r;
  endfunction

  always @(posedge clk) begin
    dir_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        m_valid[i] = 0;
        m_dirty[i] = 0;
      end
      m_hits = '0;
      m_misses = '0;
      m_dirty_n = 0;
      m_occ_n = 0;
      m_limit = 64;
      result_q.delete();
    end else begin
      if (cfg_we) m_limit = int'(cfg_wdata);
      if (out_ch.valid && out_ch.ready) begin
        if (result_q.size() == 0) begin
          $display("unexpected result item at %0t", $realtime);
          errors++;
        end else begin
          want = result_q.pop_front();
          if (out_ch.status !== want.status) report("status", out_ch.status, want.status);
          if (out_ch.slot_res !== want.slot_res)
            report("slot_res", out_ch.slot_res, want.slot_res);
          if (out_ch.hit_count !== want.hits) report("hit_count", out_ch.hit_count, want.hits);
          if (out_ch.miss_count !== want.misses)
            report("miss_count", out_ch.miss_count, want.misses);
          if (out_ch.dirty_count !== want.dirty)
            report("dirty_count", out_ch.dirty_count, want.dirty);
          if (out_ch.occupied_count !== want.occupied)
            report("occupied_count", out_ch.occupied_count, want.occupied);
        end
      end
      if (in_ch.valid && in_ch.ready)
        result_q.push_back(predict_item(in_ch.opcode, in_ch.device_id,
                                        in_ch.block_number, in_ch.slot));
    end
  end
endmodule

@@ tb/sv/tb_block_buffer_cache_directory_top.sv @@
module tb_block_buffer_cache_directory_top import bbcd_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CYCLE_LIMIT = 4000000;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       cfg_we = 0;
  logic [6:0] cfg_wdata = '0;
  int         errors, pending;
  int         idle_pct_in = 0, stall_pct_out = 0;
  longint     cycles = 0;
  logic [47:0] blk_pool[8];

  bbcd_in_if  in_ch();
  bbcd_out_if out_ch();

  block_buffer_cache_directory_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch)
  );

  bbcd_dir_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_ch(in_ch), .out_ch(out_ch), .errors(errors), .pending(pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_block_buffer_cache_directory_top failed");
      $finish;
    end
  end

  initial out_ch.ready = 0;
  always @(negedge clk)
    out_ch.ready <= ($urandom_range(99) >= stall_pct_out);

  task automatic send_item(logic [2:0] op, logic [7:0] dev, logic [47:0] blk, logic [5:0] s);
    if ($urandom_range(99) < idle_pct_in) begin
      in_ch.valid <= 0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct_in) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.device_id <= dev;
    in_ch.block_number <= blk;
    in_ch.slot <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_limit(logic [6:0] v);
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic random_item();
    logic [2:0]  op;
    logic [7:0]  dev;
    logic [47:0] blk;
    logic [5:0]  s;
    int          k;
    k = $urandom_range(99);
    if (k < 30) op = OP_READ;
    else if (k < 45) op = OP_GET;
    else if (k < 65) op = OP_RELEASE;
    else if (k < 75) op = OP_DIRTY;
    else if (k < 85) op = OP_WDONE;
    else if (k < 92) op = OP_FFAIL;
    else if (k < 97) op = OP_INVAL;
    else op = 3'd7;
    dev = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(3));
    blk = ($urandom_range(9) == 0) ? {16'($urandom), 32'($urandom)}
                                   : blk_pool[$urandom_range(7)];
    s = ($urandom_range(4) != 0) ? 6'($urandom_range(15)) : 6'($urandom);
    send_item(op, dev, blk, s);
  endtask

  initial begin
    logic [6:0] limits[5];
    in_ch.valid = 0;
    in_ch.opcode = OP_READ;
    in_ch.device_id = '0;
    in_ch.block_number = '0;
    in_ch.slot = '0;
    foreach (blk_pool[i]) blk_pool[i] = {16'($urandom), 32'($urandom)};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_item(OP_RELEASE, 8'd0, '0, 6'd0);
    send_item(OP_READ, 8'd0, '0, 6'd0);
    send_item(OP_READ, 8'd0, '0, 6'd0);
    send_item(OP_GET, 8'hFF, '1, 6'd0);
    send_item(OP_READ, 8'hFF, '1, 6'd0);
    send_item(OP_DIRTY, 8'd0, '0, 6'd0);
    send_item(OP_DIRTY, 8'd0, '0, 6'd0);
    send_item(OP_WDONE, 8'd0, '0, 6'd0);
    send_item(OP_WDONE, 8'd0, '0, 6'd0);
    send_item(OP_RELEASE, 8'd0, '0, 6'd0);
    send_item(OP_RELEASE, 8'd0, '0, 6'd0);
    send_item(OP_RELEASE, 8'd0, '0, 6'd0);
    send_item(OP_DIRTY, 8'd0, '0, 6'd1);
    send_item(OP_FFAIL, 8'd0, '0, 6'd1);
    send_item(OP_RELEASE, 8'd0, '0, 6'd63);
    send_item(OP_INVAL, 8'd9, '0, 6'd0);
    send_item(3'd7, 8'hFF, '1, 6'h3F);
    send_item(OP_INVAL, 8'd0, '0, 6'd0);
    write_limit(7'd1);
    send_item(OP_GET, 8'd1, 48'd5, 6'd0);
    send_item(OP_RELEASE, 8'd1, 48'd5, 6'd1);
    send_item(OP_GET, 8'd1, 48'd6, 6'd0);
    send_item(OP_READ, 8'd1, 48'd7, 6'd0);
    write_limit(7'd64);

    // fill every slot with pinned entries, then ask for one more
    for (int i = 0; i < ENTRIES + 1; i++) send_item(OP_GET, 8'd7, 48'(i), 6'd0);
    send_item(OP_READ, 8'd7, 48'd999, 6'd0);
    write_limit(7'd0);
    send_item(OP_READ, 8'd7, 48'd1000, 6'd0);
    for (int i = 0; i < 8; i++) send_item(OP_RELEASE, 8'd0, '0, 6'(i));
    send_item(OP_GET, 8'd7, 48'd1001, 6'd0);
    send_item(OP_INVAL, 8'd7, '0, 6'd0);

    limits = '{7'd64, 7'd127, 7'd8, 7'd1, 7'd0};
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct_in   <= (ph == 1) ? 73 : (ph == 3) ? 8 : 0;
      stall_pct_out <= (ph == 2) ? 73 : (ph == 3) ? 8 : 0;
      for (int c = 0; c < 5; c++) begin
        write_limit((ph == 3 && c == 4) ? 7'($urandom_range(2, 20)) : limits[(c + ph) % 5]);
        for (int n = 0; n < 80; n++) random_item();
      end
    end
    in_ch.valid <= 0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0)
      $display("tb_block_buffer_cache_directory_top passed");
    else
      $display("tb_block_buffer_cache_directory_top failed");
    $finish;
  end
endmodule

@@ filelist.f @@
src/bbcd_pkg.sv
src/bbcd_in_if.sv
src/bbcd_out_if.sv
src/block_buffer_cache_directory_top.sv
tb/sv/bbcd_dir_checker.sv
tb/sv/tb_block_buffer_cache_directory_top.sv
